// ===== hdl/pfla_pkg.sv =====
`timescale 1ns / 1ps

package pfla_pkg;

  localparam int unsigned PAGE_W     = 12;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned LINK_DEPTH = 4096;
  localparam int unsigned MAX_PAGES  = 4096;
  localparam int unsigned INIT_PAGES = 256;

  localparam int unsigned PAGE_LIMIT = (MAX_PAGES < LINK_DEPTH) ? MAX_PAGES : LINK_DEPTH;
  localparam int unsigned INIT_EFF   = (INIT_PAGES < LINK_DEPTH) ? INIT_PAGES : LINK_DEPTH;

  localparam logic [PAGE_W-1:0]  INIT_HEAD  = PAGE_W'(INIT_EFF - 1);
  localparam logic [COUNT_W-1:0] INIT_COUNT = COUNT_W'(INIT_EFF);
  localparam logic [COUNT_W:0]   LIMIT_EXT  = (COUNT_W + 1)'(PAGE_LIMIT);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOKUP,
    ST_GROW
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic free_push;
    logic load_bad;
    logic load_full;
    logic pop_done;
    logic grow_start;
    logic sweep_step;
    logic grow_done;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic head_empty;
    logic grow_blocked;
    logic free_bad;
    logic sweep_last;
  } dp_stat_t;

endpackage

// ===== hdl/pfla_ram.sv =====
`timescale 1ns / 1ps

module pfla_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pfla_dpath.sv =====
`timescale 1ns / 1ps

module pfla_dpath import pfla_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  input  logic [PAGE_W-1:0] page_index_i,
  output logic [PAGE_W-1:0] granted_page_o,
  output logic [1:0]        status_o
);

  logic [PAGE_W-1:0]  head_q, head_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [PAGE_W-1:0]  sweep_q, sweep_d;
  logic [PAGE_W-1:0]  sweep_end_q, sweep_end_d;
  logic [PAGE_W-1:0]  sweep_first_q, sweep_first_d;
  logic [PAGE_W-1:0]  granted_q, granted_d;
  status_e            status_q, status_d;
  logic               out_load;

  logic               mem_we;
  logic [PAGE_W-1:0]  mem_waddr, mem_wdata, mem_rdata;
  logic [COUNT_W:0]   count_dbl;

  assign count_dbl = {count_q, 1'b0};

  assign stat_o.head_empty   = (head_q == '0);
  assign stat_o.grow_blocked = (count_dbl > LIMIT_EXT);
  assign stat_o.free_bad     = (page_index_i == '0) || ({1'b0, page_index_i} >= count_q);
  assign stat_o.sweep_last   = (sweep_q == sweep_end_q);

  // sweep writes: first new page ends the list, each later page points one down
  always_comb begin
    mem_we    = cmd_i.free_push | cmd_i.sweep_step;
    mem_waddr = sweep_q;
    mem_wdata = (sweep_q == sweep_first_q) ? '0 : sweep_q - 1'b1;
    if (cmd_i.free_push) begin
      mem_waddr = page_index_i;
      mem_wdata = head_q;
    end
  end

  pfla_ram #(
    .WIDTH(PAGE_W),
    .DEPTH(LINK_DEPTH)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(head_q),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    head_d        = head_q;
    count_d       = count_q;
    sweep_d       = sweep_q;
    sweep_end_d   = sweep_end_q;
    sweep_first_d = sweep_first_q;
    granted_d     = granted_q;
    status_d      = status_q;
    out_load      = 1'b0;

    if (cmd_i.sweep_step) begin
      sweep_d = sweep_q + 1'b1;
    end
    if (cmd_i.free_push) begin
      head_d    = page_index_i;
      granted_d = '0;
      status_d  = STATUS_OK;
      out_load  = 1'b1;
    end
    if (cmd_i.load_bad) begin
      granted_d = '0;
      status_d  = STATUS_BAD_FREE;
      out_load  = 1'b1;
    end
    if (cmd_i.load_full) begin
      granted_d = '0;
      status_d  = STATUS_FULL;
      out_load  = 1'b1;
    end
    if (cmd_i.pop_done) begin
      granted_d = head_q;
      head_d    = mem_rdata;
      status_d  = STATUS_OK;
      out_load  = 1'b1;
    end
    if (cmd_i.grow_start) begin
      sweep_d       = count_q[PAGE_W-1:0];
      sweep_first_d = count_q[PAGE_W-1:0];
      sweep_end_d   = count_dbl[PAGE_W-1:0] - 1'b1;
    end
    // top new page is handed out directly; its link is the page below it
    if (cmd_i.grow_done) begin
      granted_d = sweep_end_q;
      head_d    = sweep_end_q - 1'b1;
      count_d   = {1'b0, sweep_end_q} + 1'b1;
      status_d  = STATUS_OK;
      out_load  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= INIT_HEAD;
      count_q       <= INIT_COUNT;
      sweep_q       <= PAGE_W'(1);
      sweep_first_q <= PAGE_W'(1);
      sweep_end_q   <= INIT_HEAD;
    end else begin
      head_q        <= head_d;
      count_q       <= count_d;
      sweep_q       <= sweep_d;
      sweep_first_q <= sweep_first_d;
      sweep_end_q   <= sweep_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      granted_q <= granted_d;
      status_q  <= status_d;
    end
  end

  assign granted_page_o = granted_q;
  assign status_o       = status_q;

endmodule

// ===== hdl/pfla_ctrl.sv =====
`timescale 1ns / 1ps

module pfla_ctrl import pfla_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     cmd_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dp_cmd_t  dp_cmd_o,
  input  dp_stat_t dp_stat_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_load;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '0;
    unique case (state_q)
      ST_INIT: begin
        dp_cmd_o.sweep_step = 1'b1;
        if (dp_stat_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_FREE) begin
            if (dp_stat_i.free_bad) begin
              dp_cmd_o.load_bad = 1'b1;
            end else begin
              dp_cmd_o.free_push = 1'b1;
            end
          end else if (!dp_stat_i.head_empty) begin
            state_d = ST_LOOKUP;
          end else if (dp_stat_i.grow_blocked) begin
            dp_cmd_o.load_full = 1'b1;
          end else begin
            dp_cmd_o.grow_start = 1'b1;
            state_d             = ST_GROW;
          end
        end
      end
      ST_LOOKUP: begin
        dp_cmd_o.pop_done = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_GROW: begin
        dp_cmd_o.sweep_step = 1'b1;
        if (dp_stat_i.sweep_last) begin
          dp_cmd_o.grow_done = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_load = dp_cmd_o.free_push | dp_cmd_o.load_bad | dp_cmd_o.load_full |
                    dp_cmd_o.pop_done | dp_cmd_o.grow_done;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // lookup and growth finish into an empty output slot
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP || state_q == ST_GROW) |-> !out_valid_q)
    else $error("output slot busy during multi-cycle allocate");

  // a pop from a non-empty list goes through the link lookup
  a_pop_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_ALLOC && !dp_stat_i.head_empty) |=> state_q == ST_LOOKUP)
    else $error("allocate skipped link lookup");

  // nothing is accepted outside the idle state
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT || state_q == ST_GROW) |-> !in_ready_o)
    else $error("input accepted during link sweep");

endmodule

// ===== hdl/page_free_list_allocator.sv =====
`timescale 1ns / 1ps

// Page allocator with a linked free list held in a 4096-entry link RAM.
// Input channel (in_valid_i/in_ready_o): cmd_i selects allocate or free;
// page_index_i names the page to free. Output channel (out_valid_o/
// out_ready_i): one result beat per input beat, granted_page_o and status_o
// (ok, store full, invalid page freed).
// A free or a rejected command answers in the cycle after its beat is
// accepted; an allocate from a non-empty list first passes the lookup
// state, which waits on the registered read of the link RAM. An allocate that finds
// the list empty doubles the page count, writing one link entry per cycle,
// and answers once the new links are written.
// One free per cycle while the receiver keeps out_ready_i high; an allocate that
// needs the lookup or a growth sweep holds off the next beat until it is done.
// Reset: the link RAM is filled for the initial pages, one entry per cycle, while in_ready_o stays low.
// A stalled receiver holds the result register; a new beat is taken only
// when the register is empty or drains in that same cycle.
module page_free_list_allocator import pfla_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [PAGE_W-1:0] page_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PAGE_W-1:0] granted_page_o,
  output logic [1:0]        status_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  pfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .dp_cmd_o   (dp_cmd),
    .dp_stat_i  (dp_stat)
  );

  pfla_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .page_index_i  (page_index_i),
    .granted_page_o(granted_page_o),
    .status_o      (status_o)
  );

endmodule
